// File: rtl/mcfl_pkg.sv
// ----------------------------------------------------------------------------
// mcfl_pkg: shared types and constants for the motor command frame link
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcfl_pkg;

    // frame geometry
    localparam int FrameLen = 6;
    localparam int PosW     = 3;

    // receive frame markers and command codes
    localparam logic [7:0] RX_HEAD  = 8'h43;
    localparam logic [7:0] RX_TAIL  = 8'h68;
    localparam logic [7:0] CMD_STOP = 8'h26;
    localparam logic [7:0] CMD_FWD  = 8'h82;
    localparam logic [7:0] CMD_REV  = 8'h83;

    // reply frame markers
    localparam logic [7:0] TX_HEAD  = 8'h65;
    localparam logic [7:0] TX_TAIL  = 8'h6E;
    localparam logic [7:0] REPLY_OK = 8'h01;

    // input word opcodes
    localparam logic OP_RX_BYTE = 1'b0;
    localparam logic OP_SEND    = 1'b1;

    // result word kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    // verdict status codes
    localparam logic [1:0] ST_FRAME_ERR = 2'd0;
    localparam logic [1:0] ST_ACCEPTED  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN   = 2'd2;

    // verdict action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_STOP = 2'd1;
    localparam logic [1:0] ACT_FWD  = 2'd2;
    localparam logic [1:0] ACT_REV  = 2'd3;

    // reply byte positions
    localparam logic [PosW-1:0] IDX_HEAD  = 3'd0;
    localparam logic [PosW-1:0] IDX_OK    = 3'd1;
    localparam logic [PosW-1:0] IDX_HI    = 3'd2;
    localparam logic [PosW-1:0] IDX_LO    = 3'd3;
    localparam logic [PosW-1:0] IDX_SUM   = 3'd4;
    localparam logic [PosW-1:0] IDX_LAST  = 3'd5;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [1:0]  action;
        logic [15:0] step_count;
        logic [7:0]  tx_byte;
        logic        last;
    } out_word_t;

endpackage

// File: rtl/mcfl_frame_rx.sv
// ----------------------------------------------------------------------------
// mcfl_frame_rx: receive byte collector and frame checker
// Stores the first five bytes of a frame, judges it on the sixth byte and
// keeps the step count of the last good frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcfl_frame_rx (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_en,
    input  logic [7:0]          rx_byte,
    output logic                verdict_due,
    output mcfl_pkg::out_word_t verdict,
    output logic [15:0]         saved_count
);
    import mcfl_pkg::*;

    logic [7:0]      frame_mem [0:FrameLen-2];
    logic [PosW-1:0] pos_reg;
    logic [PosW-1:0] pos_next;
    logic [15:0]     step_reg;
    logic [15:0]     step_next;
    logic [7:0]      sum;
    logic [15:0]     count;
    logic            good;

    // sixth byte of a frame, also covers out-of-range positions
    assign verdict_due = (pos_reg >= PosW'(FrameLen - 1));

    // frame check on the stored bytes and the incoming tail byte
    always_comb begin
        sum   = frame_mem[1] + frame_mem[2] + frame_mem[3];
        count = {frame_mem[2], frame_mem[3]};
        good  = (frame_mem[0] == RX_HEAD) && (rx_byte == RX_TAIL) &&
                (frame_mem[4] == sum);
    end

    // verdict word
    always_comb begin
        verdict            = '0;
        verdict.kind       = KIND_VERDICT;
        verdict.last       = 1'b1;
        verdict.status     = ST_FRAME_ERR;
        verdict.action     = ACT_NONE;
        if (good) begin
            verdict.step_count = count;
            case (frame_mem[1])
                CMD_STOP: begin
                    verdict.status = ST_ACCEPTED;
                    verdict.action = ACT_STOP;
                end
                CMD_FWD: begin
                    verdict.status = ST_ACCEPTED;
                    verdict.action = ACT_FWD;
                end
                CMD_REV: begin
                    verdict.status = ST_ACCEPTED;
                    verdict.action = ACT_REV;
                end
                default: begin
                    verdict.status = ST_UNKNOWN;
                    verdict.action = ACT_NONE;
                end
            endcase
        end
    end

    // position and step count next values
    always_comb begin
        pos_next  = pos_reg;
        step_next = step_reg;
        if (byte_en) begin
            if (verdict_due) begin
                pos_next = '0;
                if (good) begin
                    step_next = count;
                end
            end else begin
                pos_next = pos_reg + PosW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            step_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            step_reg <= step_next;
        end
    end

    // frame byte store
    always_ff @(posedge aclk) begin
        if (byte_en && !verdict_due) begin
            frame_mem[pos_reg] <= rx_byte;
        end
    end

    assign saved_count = step_reg;

endmodule

// File: rtl/mcfl_reply_gen.sv
// ----------------------------------------------------------------------------
// mcfl_reply_gen: reply frame sequencer
// Steps through the six reply bytes, one per output load, holding off new
// words until the last byte is handed over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcfl_reply_gen (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                advance,
    input  logic [15:0]         saved_count,
    output logic                busy,
    output mcfl_pkg::out_word_t reply
);
    import mcfl_pkg::*;

    logic            active_reg;
    logic            active_next;
    logic [PosW-1:0] idx_reg;
    logic [PosW-1:0] idx_next;
    logic [PosW-1:0] idx;
    logic [7:0]      sum;

    // byte 0 goes out on the request itself
    assign idx  = active_reg ? idx_reg : IDX_HEAD;
    assign busy = active_reg;
    assign sum  = REPLY_OK + saved_count[15:8] + saved_count[7:0];

    // reply byte selection
    always_comb begin
        reply      = '0;
        reply.kind = KIND_REPLY;
        reply.last = (idx == IDX_LAST);
        case (idx)
            IDX_HEAD: reply.tx_byte = TX_HEAD;
            IDX_OK:   reply.tx_byte = REPLY_OK;
            IDX_HI:   reply.tx_byte = saved_count[15:8];
            IDX_LO:   reply.tx_byte = saved_count[7:0];
            IDX_SUM:  reply.tx_byte = sum;
            default:  reply.tx_byte = TX_TAIL;
        endcase
    end

    // sequencer next values
    always_comb begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (start) begin
            active_next = 1'b1;
            idx_next    = IDX_OK;
        end else if (active_reg && advance) begin
            idx_next = idx_reg + PosW'(1);
            if (idx_reg == IDX_LAST) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= IDX_HEAD;
        end else begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

// File: rtl/motor_command_frame_link.sv
// ----------------------------------------------------------------------------
// motor_command_frame_link: six-byte command frame receiver and reply sender
// A verdict or the first reply byte is registered at accept, valid the next cycle.
// Throughput: one word per cycle when the output is free; a send request blocks
// input after its accept while bytes 1 to 5 load, which output stalls prolong.
// Reset: aresetn sync low; clears position, step count, sequencer, valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_command_frame_link (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mcfl_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mcfl_pkg::out_word_t m_data
);
    import mcfl_pkg::*;

    logic        out_free;
    logic        accept;
    logic        byte_en;
    logic        send_start;
    logic        reply_more;
    logic        verdict_due;
    logic        load_verdict;
    logic        load_reply;
    logic        reply_busy;
    logic [15:0] saved_count;
    out_word_t   verdict;
    out_word_t   reply;
    logic        m_valid_reg;
    logic        m_valid_next;
    out_word_t   m_data_reg;
    out_word_t   m_data_next;

    // input handshake
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = !reply_busy && out_free;
    assign accept     = s_valid && s_ready;
    assign byte_en    = accept && (s_data.opcode == OP_RX_BYTE);
    assign send_start = accept && (s_data.opcode == OP_SEND);
    assign reply_more = reply_busy && out_free;

    mcfl_frame_rx u_frame_rx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_en     (byte_en),
        .rx_byte     (s_data.rx_byte),
        .verdict_due (verdict_due),
        .verdict     (verdict),
        .saved_count (saved_count)
    );

    mcfl_reply_gen u_reply_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (send_start),
        .advance     (out_free),
        .saved_count (saved_count),
        .busy        (reply_busy),
        .reply       (reply)
    );

    // output register load
    assign load_verdict = byte_en && verdict_due;
    assign load_reply   = send_start || reply_more;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_verdict) begin
            m_valid_next = 1'b1;
            m_data_next  = verdict;
        end else if (load_reply) begin
            m_valid_next = 1'b1;
            m_data_next  = reply;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
